@@ rtl/mhlp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the multiplicative hash key table
// no dependencies

package mhlp_pkg;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	localparam int          MULT_BITS  = 16;
	localparam int          COUNT_BITS = 9;
	localparam logic [15:0] MULT_RESET = 16'd60147;
	localparam logic [8:0]  COUNT_MAX  = 9'd511;

	typedef struct packed {
		logic        req_type;
		logic [31:0] key;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] probe_count;
	} rsp_t;

endpackage

@@ rtl/mhlp_hash.sv @@
`timescale 1ns / 1ps
// home slot of a key: low bits of multiplier times key, top table bits kept
// depends on mhlp_pkg

module mhlp_hash
	import mhlp_pkg::*;
#(
	parameter int TABLE_BITS = 9,
	parameter int HASH_BITS  = 16,
	parameter int KEY_BITS   = 32
) (
	input  logic [MULT_BITS-1:0]  mult,
	input  logic [KEY_BITS-1:0]   key,
	output logic [TABLE_BITS-1:0] home
);

	logic [31:0]           key_lo;
	logic [MULT_BITS+31:0] prod;
	logic [HASH_BITS-1:0]  prod_h;

	// only the low hash bits of the product matter, so 32 key bits suffice
	assign key_lo = 32'(key);
	assign prod   = (MULT_BITS + 32)'(mult) * (MULT_BITS + 32)'(key_lo);
	assign prod_h = prod[HASH_BITS-1:0];

	generate
		if (HASH_BITS >= TABLE_BITS) begin : g_shift
			assign home = prod_h[HASH_BITS-1 -: TABLE_BITS];
		end else begin : g_direct
			assign home = TABLE_BITS'(prod_h);
		end
	endgenerate

endmodule

@@ rtl/mhlp_table.sv @@
`timescale 1ns / 1ps
// slot memory holding a valid mark and key per slot, with clearing sweep after reset
// depends on mhlp_pkg

module mhlp_table
	import mhlp_pkg::*;
#(
	parameter int TABLE_BITS = 9,
	parameter int KEY_BITS   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [TABLE_BITS-1:0] rd_addr,
	output logic [KEY_BITS:0]     rd_data,
	input  logic                  wr_en,
	input  logic [TABLE_BITS-1:0] wr_addr,
	input  logic [KEY_BITS-1:0]   wr_key,
	output logic                  clr_busy
);

	localparam int TABLE_SIZE = 1 << TABLE_BITS;

	logic [KEY_BITS:0]     mem [TABLE_SIZE];
	logic [KEY_BITS:0]     rd_data_q;
	logic [TABLE_BITS-1:0] clr_addr_q;
	logic                  clr_busy_q;
	logic                  mem_we;
	logic [TABLE_BITS-1:0] mem_wa;
	logic [KEY_BITS:0]     mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {TABLE_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// sweep owns the write port until every slot is marked empty
	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else begin
			mem_we = wr_en;
			mem_wa = wr_addr;
			mem_wd = {1'b1, wr_key};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

endmodule

@@ rtl/multiplicative_hash_linear_probe.sv @@
`timescale 1ns / 1ps
// from input beat to result valid: S_MUL hash, probe loop over n slots (1 .. 2^TABLE_BITS), S_RESP,
// output register; one request at a time, taken in S_IDLE; one slot read per cycle from the single read port
// the multiplier runs once per request, then a read-compare loop walks the slots
// reset: once arst_n is released the slot memory is swept empty, one slot a cycle, and in_ready
// rises in the cycle after the sweep ends; the multiplier register returns to 60147

module multiplicative_hash_linear_probe
	import mhlp_pkg::*;
#(
	parameter int TABLE_BITS = 9,
	parameter int HASH_BITS  = 16,
	parameter int KEY_BITS   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [MULT_BITS-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  req_t                 in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rsp_t                 out_data
);

	localparam int TABLE_SIZE = 1 << TABLE_BITS;

	// sequencer states
	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_MUL   = 5'b00100,
		S_PROBE = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [MULT_BITS-1:0]    mult_q;
	logic                    type_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [TABLE_BITS-1:0]   iss_q;       // slot address being read
	logic [TABLE_BITS:0]     iss_cnt_q;   // reads issued for this request
	logic                    chk_v_q;     // read data in flight is for this request
	logic                    chk_last_q;  // read data is the last slot of the pass
	logic [TABLE_BITS-1:0]   chk_slot_q;
	logic [COUNT_BITS-1:0]   cnt_q;
	rsp_t                    res_q;
	logic                    out_valid_q;
	rsp_t                    out_data_q;

	logic [TABLE_BITS-1:0]   home;
	logic [KEY_BITS:0]       rd_data;
	logic                    clr_busy;
	logic                    slot_valid;
	logic [KEY_BITS-1:0]     slot_key;
	logic                    hit;
	logic                    passed;
	logic                    fail;
	logic                    tbl_we;
	logic                    issue;
	logic                    in_beat;
	logic                    rsp_load;

	mhlp_hash #(
		.TABLE_BITS (TABLE_BITS),
		.HASH_BITS  (HASH_BITS),
		.KEY_BITS   (KEY_BITS)
	) u_hash (
		.mult (mult_q),
		.key  (key_q),
		.home (home)
	);

	mhlp_table #(
		.TABLE_BITS (TABLE_BITS),
		.KEY_BITS   (KEY_BITS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (iss_q),
		.rd_data  (rd_data),
		.wr_en    (tbl_we),
		.wr_addr  (chk_slot_q),
		.wr_key   (key_q),
		.clr_busy (clr_busy)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_beat  = in_valid && in_ready;

	// compare stage: look at the slot read in the previous cycle
	assign slot_valid = rd_data[KEY_BITS];
	assign slot_key   = rd_data[KEY_BITS-1:0];

	// insert stops at the first empty slot, search at the first matching occupied one
	always_comb begin
		if (type_q == REQ_INSERT) begin
			hit = chk_v_q && !slot_valid;
		end else begin
			hit = chk_v_q && slot_valid && (slot_key == key_q);
		end
	end

	// occupied slots passed without success count towards probe_count
	assign passed = chk_v_q && slot_valid && !hit;
	assign fail   = chk_v_q && chk_last_q && !hit;
	assign tbl_we = (state_q == S_PROBE) && hit && (type_q == REQ_INSERT);
	assign issue  = (iss_cnt_q != (TABLE_BITS + 1)'(TABLE_SIZE));

	// result waits in S_RESP until the output register is free
	assign rsp_load = (state_q == S_RESP) && (!out_valid_q || out_ready);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			mult_q      <= MULT_RESET;
			chk_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mult_q <= cfg_wr_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				S_CLEAR: begin
					if (!clr_busy) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					chk_v_q <= 1'b0;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (hit || fail) begin
						chk_v_q <= 1'b0;
						state_q <= S_RESP;
					end else begin
						chk_v_q <= issue;
					end
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			type_q <= in_data.req_type;
			key_q  <= KEY_BITS'(in_data.key);
		end
		if (state_q == S_MUL) begin
			iss_q     <= home;
			iss_cnt_q <= '0;
			cnt_q     <= '0;
		end
		if (state_q == S_PROBE) begin
			chk_slot_q <= iss_q;
			chk_last_q <= (iss_cnt_q == (TABLE_BITS + 1)'(TABLE_SIZE - 1));
			if (issue) begin
				iss_q     <= iss_q + 1'b1;
				iss_cnt_q <= iss_cnt_q + 1'b1;
			end
			// saturating count of occupied slots passed
			if (passed && (cnt_q != COUNT_MAX)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (hit) begin
				res_q.status      <= ST_OK;
				res_q.probe_count <= cnt_q;
			end else if (fail) begin
				res_q.status      <= (type_q == REQ_INSERT) ? ST_FULL : ST_MISS;
				res_q.probe_count <= '0;
			end
		end
		if (rsp_load) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// no request is taken while the clearing sweep runs
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !clr_busy)
		else $error("request accepted during clearing sweep");

	// table writes only come from an insert in the probe loop
	a_write_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> (state_q == S_PROBE) && (type_q == REQ_INSERT) && chk_v_q)
		else $error("table write outside insert probe");

	// a request beat always starts the hash step
	a_beat_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == S_MUL))
		else $error("request beat did not start hash step");

	// a loaded result appears on the output next cycle
	a_load_to_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> out_valid && (state_q == S_IDLE))
		else $error("result not presented after load");

	// compare data in flight only inside the probe loop
	a_chk_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		chk_v_q |-> (state_q == S_PROBE))
		else $error("compare stage active outside probe loop");

endmodule
